// ===== rtl/r2p_pkg.sv =====
// Shared constants, angle table and helper functions for the rectangular to polar converter.
package r2p_pkg;

   localparam int R2P_COORD_WIDTH     = 16;
   localparam int R2P_ROTATION_STAGES = 16;

   // Datapath guard bits below the coordinate LSB
   localparam int R2P_GUARD_BITS = 24;
   localparam int R2P_OUT_WIDTH  = 16;

   // Angle accumulator: signed, 2^-15 degree per LSB
   localparam int R2P_ZW          = 27;
   localparam int R2P_PHASE_SHIFT = 8;
   localparam int R2P_QW          = R2P_ZW - R2P_PHASE_SHIFT;
   localparam int R2P_STEP_COUNT  = 32;

   localparam logic signed [R2P_ZW-1:0] R2P_HALF_TURN_Z = 27'sd5898240;
   localparam logic signed [R2P_ZW-1:0] R2P_FULL_TURN_Z = 27'sd11796480;
   localparam logic signed [R2P_ZW-1:0] R2P_PHASE_ROUND = 27'sd128;

   localparam logic [R2P_QW-1:0] R2P_PHASE_FULL = 19'd46080;

   localparam logic [R2P_OUT_WIDTH-1:0] R2P_PHASE_0   = 16'd0;
   localparam logic [R2P_OUT_WIDTH-1:0] R2P_PHASE_90  = 16'd11520;
   localparam logic [R2P_OUT_WIDTH-1:0] R2P_PHASE_180 = 16'd23040;
   localparam logic [R2P_OUT_WIDTH-1:0] R2P_PHASE_270 = 16'd34560;

   // round(atan(2^-i) in degrees * 2^15)
   localparam int R2P_ANGLE_STEP [R2P_STEP_COUNT] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57,
      29, 14, 7, 4, 2, 1, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0
   };

   function automatic int r2p_angle_step(int idx);
      if (idx >= 0 && idx < R2P_STEP_COUNT) begin
         return R2P_ANGLE_STEP[idx];
      end
      return 0;
   endfunction

   // Pipeline stages between the input register and the output register
   function automatic int r2p_iter_count(int cw, int rot);
      return (rot > cw + 2) ? rot : cw + 2;
   endfunction

endpackage

// ===== rtl/r2p_if.sv =====
// Valid/ready channel interfaces for coordinate requests and polar responses.
interface r2p_req_if
   import r2p_pkg::*;
#(
   parameter int COORD_WIDTH = R2P_COORD_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;

   modport source (output valid, x_coord, y_coord, input ready);
   modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface r2p_rsp_if
   import r2p_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [R2P_OUT_WIDTH-1:0] magnitude;
   logic [R2P_OUT_WIDTH-1:0] phase_angle;

   modport source (output valid, magnitude, phase_angle, input ready);
   modport sink (input valid, magnitude, phase_angle, output ready);
endinterface

// ===== rtl/r2p_cordic_step.sv =====
// One CORDIC vectoring micro-rotation with a fixed shift and angle step.
module r2p_cordic_step
   import r2p_pkg::*;
#(
   parameter int                        DW    = 43,
   parameter int                        SHIFT = 0,
   parameter logic signed [R2P_ZW-1:0]  STEP  = '0
) (
   input  logic signed [DW-1:0]     x_cur,
   input  logic signed [DW-1:0]     y_cur,
   input  logic signed [R2P_ZW-1:0] z_cur,
   output logic signed [DW-1:0]     x_rot,
   output logic signed [DW-1:0]     y_rot,
   output logic signed [R2P_ZW-1:0] z_rot
);

   logic signed [DW-1:0] x_shr;
   logic signed [DW-1:0] y_shr;

   assign x_shr = x_cur >>> SHIFT;
   assign y_shr = y_cur >>> SHIFT;

   // Drive y toward zero; the sign of y picks the rotation direction
   always_comb begin
      if (!y_cur[DW-1]) begin
         x_rot = x_cur + y_shr;
         y_rot = y_cur - x_shr;
         z_rot = z_cur + STEP;
      end else begin
         x_rot = x_cur - y_shr;
         y_rot = y_cur + x_shr;
         z_rot = z_cur - STEP;
      end
   end

endmodule

// ===== rtl/r2p_root_step.sv =====
// One digit step of the bit-pair integer square root.
module r2p_root_step #(
   parameter int RW      = 33,
   parameter int BIT_POS = 0
) (
   input  logic [RW-1:0] rem_cur,
   input  logic [RW-1:0] root_cur,
   output logic [RW-1:0] rem_upd,
   output logic [RW-1:0] root_upd
);

   localparam logic [RW-1:0] BIT_VAL = RW'(1) << BIT_POS;

   logic [RW-1:0] trial;

   assign trial = root_cur + BIT_VAL;

   always_comb begin
      if (rem_cur >= trial) begin
         rem_upd  = rem_cur - trial;
         root_upd = (root_cur >> 1) + BIT_VAL;
      end else begin
         rem_upd  = rem_cur;
         root_upd = root_cur >> 1;
      end
   end

endmodule

// ===== rtl/rectangular_to_polar.sv =====
// Rectangular to polar converter: pipelined CORDIC phase and digit-serial square root.
//
// Requests carry a signed pair (x_coord, y_coord) on req_port; responses carry
// the rounded magnitude sqrt(x^2 + y^2) and the phase atan2(y, x) in 1/128
// degree, 0 up to 46079, on rsp_port. A transfer happens on a clock edge with
// valid and ready both high.
// Throughput is one transfer per cycle while rsp_port.ready keeps taking
// responses. ITER_COUNT, the depth of the iteration chain, is the larger of
// ROTATION_STAGES and COORD_WIDTH + 2; that depth comes from one root digit
// per stage of the square root chain and one micro-rotation per stage of the
// CORDIC chain, which run side by side.
// Each stage advances when it is empty or the next one moves, so bubbles
// collapse and req_port.ready stays high while any stage is free, even with a
// response waiting. A stalled response holds its payload.
// Synchronous reset drops every item in flight; no clearing pass is needed.
module rectangular_to_polar
   import r2p_pkg::*;
#(
   parameter int COORD_WIDTH     = R2P_COORD_WIDTH,
   parameter int ROTATION_STAGES = R2P_ROTATION_STAGES
) (
   input  logic       clock,
   input  logic       reset,
   r2p_req_if.sink    req_port,
   r2p_rsp_if.source  rsp_port
);

   localparam int ITER_COUNT = r2p_iter_count(COORD_WIDTH, ROTATION_STAGES);
   localparam int SW         = 2 * COORD_WIDTH;
   localparam int RW         = SW + 1;
   localparam int DW         = COORD_WIDTH + R2P_GUARD_BITS + 3;

   typedef struct packed {
      logic signed [DW-1:0]     x;
      logic signed [DW-1:0]     y;
      logic signed [R2P_ZW-1:0] z;
      logic [COORD_WIDTH-1:0]   abs_x;
      logic [COORD_WIDTH-1:0]   abs_y;
      logic [SW-1:0]            sq_x;
      logic [SW-1:0]            sq_y;
      logic [RW-1:0]            rem;
      logic [RW-1:0]            root;
      logic                     x_zero;
      logic                     y_zero;
      logic                     x_neg;
      logic                     y_pos;
   } stage_type;

   stage_type               pipe_ff [ITER_COUNT+1];
   stage_type               pipe_in [ITER_COUNT+1];
   logic [ITER_COUNT:0]     pipe_valid_ff;
   logic [ITER_COUNT:0]     stage_en;

   logic                     out_en;
   logic                     out_valid_ff;
   logic [R2P_OUT_WIDTH-1:0] magnitude_ff;
   logic [R2P_OUT_WIDTH-1:0] magnitude_in;
   logic [R2P_OUT_WIDTH-1:0] phase_ff;
   logic [R2P_OUT_WIDTH-1:0] phase_in;

   logic signed [COORD_WIDTH:0] x_ext;
   logic signed [COORD_WIDTH:0] y_ext;
   logic signed [COORD_WIDTH:0] x_turn;
   logic signed [COORD_WIDTH:0] y_turn;
   logic signed [COORD_WIDTH:0] y_abs;

   // ---------------- handshake ----------------

   assign out_en         = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = stage_en[0];

   for (genvar s = 0; s <= ITER_COUNT; s++) begin : g_en
      if (s == ITER_COUNT) begin : g_last
         assign stage_en[s] = !pipe_valid_ff[s] || out_en;
      end else begin : g_mid
         assign stage_en[s] = !pipe_valid_ff[s] || stage_en[s+1];
      end
   end

   // ---------------- input stage ----------------

   assign x_ext  = {req_port.x_coord[COORD_WIDTH-1], req_port.x_coord};
   assign y_ext  = {req_port.y_coord[COORD_WIDTH-1], req_port.y_coord};
   // Left half plane: turn the vector by 180 degrees
   assign x_turn = x_ext[COORD_WIDTH] ? -x_ext : x_ext;
   assign y_turn = x_ext[COORD_WIDTH] ? -y_ext : y_ext;
   assign y_abs  = y_ext[COORD_WIDTH] ? -y_ext : y_ext;

   always_comb begin
      pipe_in[0]        = '0;
      pipe_in[0].x      = DW'(x_turn) <<< R2P_GUARD_BITS;
      pipe_in[0].y      = DW'(y_turn) <<< R2P_GUARD_BITS;
      pipe_in[0].z      = x_ext[COORD_WIDTH] ? R2P_HALF_TURN_Z : '0;
      pipe_in[0].abs_x  = x_turn[COORD_WIDTH-1:0];
      pipe_in[0].abs_y  = y_abs[COORD_WIDTH-1:0];
      pipe_in[0].x_zero = (req_port.x_coord == '0);
      pipe_in[0].y_zero = (req_port.y_coord == '0);
      pipe_in[0].x_neg  = x_ext[COORD_WIDTH];
      pipe_in[0].y_pos  = !y_ext[COORD_WIDTH] && (req_port.y_coord != '0);
   end

   // ---------------- iteration stages ----------------

   for (genvar s = 1; s <= ITER_COUNT; s++) begin : g_stage
      localparam int ROT_IDX  = s - 1;
      localparam int ROOT_IDX = s - 3;

      logic signed [DW-1:0]     x_rot;
      logic signed [DW-1:0]     y_rot;
      logic signed [R2P_ZW-1:0] z_rot;
      logic [RW-1:0]            rem_upd;
      logic [RW-1:0]            root_upd;

      if (ROT_IDX < ROTATION_STAGES) begin : g_rot
         r2p_cordic_step #(
            .DW    (DW),
            .SHIFT (ROT_IDX),
            .STEP  (R2P_ZW'(r2p_angle_step(ROT_IDX)))
         ) u_rot (
            .x_cur (pipe_ff[s-1].x),
            .y_cur (pipe_ff[s-1].y),
            .z_cur (pipe_ff[s-1].z),
            .x_rot (x_rot),
            .y_rot (y_rot),
            .z_rot (z_rot)
         );
      end else begin : g_rot_hold
         assign x_rot = pipe_ff[s-1].x;
         assign y_rot = pipe_ff[s-1].y;
         assign z_rot = pipe_ff[s-1].z;
      end

      if (s >= 3 && ROOT_IDX < COORD_WIDTH) begin : g_root
         r2p_root_step #(
            .RW      (RW),
            .BIT_POS (2 * (COORD_WIDTH - 1 - ROOT_IDX))
         ) u_root (
            .rem_cur  (pipe_ff[s-1].rem),
            .root_cur (pipe_ff[s-1].root),
            .rem_upd  (rem_upd),
            .root_upd (root_upd)
         );
      end else if (s == 2) begin : g_sum
         assign rem_upd  = RW'(pipe_ff[s-1].sq_x) + RW'(pipe_ff[s-1].sq_y);
         assign root_upd = '0;
      end else begin : g_root_hold
         assign rem_upd  = pipe_ff[s-1].rem;
         assign root_upd = pipe_ff[s-1].root;
      end

      always_comb begin
         pipe_in[s]      = pipe_ff[s-1];
         pipe_in[s].x    = x_rot;
         pipe_in[s].y    = y_rot;
         pipe_in[s].z    = z_rot;
         pipe_in[s].rem  = rem_upd;
         pipe_in[s].root = root_upd;
         if (s == 1) begin
            pipe_in[s].sq_x = SW'(pipe_ff[s-1].abs_x) * SW'(pipe_ff[s-1].abs_x);
            pipe_in[s].sq_y = SW'(pipe_ff[s-1].abs_y) * SW'(pipe_ff[s-1].abs_y);
         end
      end
   end

   // ---------------- pipeline registers ----------------

   for (genvar s = 0; s <= ITER_COUNT; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            pipe_ff[s] <= pipe_in[s];
         end
      end

      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               pipe_valid_ff[s] <= 1'b0;
            end else if (stage_en[s]) begin
               pipe_valid_ff[s] <= req_port.valid;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               pipe_valid_ff[s] <= 1'b0;
            end else if (stage_en[s]) begin
               pipe_valid_ff[s] <= pipe_valid_ff[s-1];
            end
         end
      end
   end

   // ---------------- rounding and output ----------------

   always_comb begin
      logic signed [R2P_ZW-1:0] total;
      logic [R2P_QW-1:0]        quot;
      logic [RW-1:0]            root_rnd;

      total = pipe_ff[ITER_COUNT].z + R2P_FULL_TURN_Z + R2P_PHASE_ROUND;
      if (total[R2P_ZW-1]) begin
         total = '0;
      end
      quot = total[R2P_ZW-1:R2P_PHASE_SHIFT];
      // Wrap a phase that rounds up to a full turn
      if (quot >= R2P_PHASE_FULL) begin
         quot = quot - R2P_PHASE_FULL;
      end

      if (pipe_ff[ITER_COUNT].y_zero) begin
         phase_in = pipe_ff[ITER_COUNT].x_neg ? R2P_PHASE_180 : R2P_PHASE_0;
      end else if (pipe_ff[ITER_COUNT].x_zero) begin
         phase_in = pipe_ff[ITER_COUNT].y_pos ? R2P_PHASE_90 : R2P_PHASE_270;
      end else begin
         phase_in = quot[R2P_OUT_WIDTH-1:0];
      end

      root_rnd = pipe_ff[ITER_COUNT].root;
      if (pipe_ff[ITER_COUNT].rem > pipe_ff[ITER_COUNT].root) begin
         root_rnd = root_rnd + RW'(1);
      end
      magnitude_in = root_rnd[R2P_OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= pipe_valid_ff[ITER_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         magnitude_ff <= magnitude_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.magnitude   = magnitude_ff;
   assign rsp_port.phase_angle = phase_ff;

endmodule

// ===== rtl/r2p_checker.sv =====
// Port-level checks for the rectangular to polar converter, bound to the top level.
module r2p_checker
   import r2p_pkg::*;
#(
   parameter int COORD_WIDTH     = R2P_COORD_WIDTH,
   parameter int ROTATION_STAGES = R2P_ROTATION_STAGES
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [R2P_OUT_WIDTH-1:0] rsp_magnitude,
   input logic [R2P_OUT_WIDTH-1:0] rsp_phase_angle
);

   // Items the block can hold: input register, iteration stages, output register
   localparam int DEPTH = r2p_iter_count(COORD_WIDTH, ROTATION_STAGES) + 2;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] outstanding_ff;
   logic [CNT_W-1:0] outstanding_in;
   logic             req_xfer;
   logic             rsp_xfer;

   assign req_xfer       = req_valid && req_ready;
   assign rsp_xfer       = rsp_valid && rsp_ready;
   assign outstanding_in = outstanding_ff + CNT_W'(req_xfer) - CNT_W'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_magnitude) && $stable(rsp_phase_angle))
      else $error("response changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("response without a matching request");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == CNT_W'(DEPTH) && !rsp_ready |-> !req_ready)
      else $error("request taken with every stage full and output stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rectangular_to_polar r2p_checker #(
   .COORD_WIDTH     (COORD_WIDTH),
   .ROTATION_STAGES (ROTATION_STAGES)
) u_r2p_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_magnitude   (rsp_port.magnitude),
   .rsp_phase_angle (rsp_port.phase_angle)
);
